// ===== design/sfir_pkg.sv =====
`timescale 1ns / 1ps

package sfir_pkg;

	localparam int MAX_TAPS_DEF     = 512;
	localparam int SAMPLE_BITS_DEF  = 16;
	localparam int NUM_CHANNELS_DEF = 2;

	localparam int TAPS_W     = 10;
	localparam int TAP_IDX_W  = 9;
	localparam int TAPS_RESET = 491;

	typedef enum logic {
		REQ_LOAD   = 1'b0,
		REQ_SAMPLE = 1'b1
	} req_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_ROUND,
		ST_FINISH
	} fir_state_t;

endpackage

// ===== design/sfir_if.sv =====
`timescale 1ns / 1ps

interface sfir_in_if #(
	parameter int SAMPLE_BITS = sfir_pkg::SAMPLE_BITS_DEF
);
	import sfir_pkg::*;

	logic                          valid;
	logic                          ready;
	logic                          req_type;
	logic                          channel;
	logic [TAP_IDX_W-1:0]          tap_index;
	logic signed [SAMPLE_BITS-1:0] data_value;

	modport source (output valid, req_type, channel, tap_index, data_value, input ready);
	modport sink   (input valid, req_type, channel, tap_index, data_value, output ready);
endinterface

interface sfir_out_if #(
	parameter int SAMPLE_BITS = sfir_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic                          out_channel;
	logic signed [SAMPLE_BITS-1:0] filtered_sample;

	modport source (output valid, out_channel, filtered_sample, input ready);
	modport sink   (input valid, out_channel, filtered_sample, output ready);
endinterface

// ===== design/stereo_fir_filter_stateful.sv =====
`timescale 1ns / 1ps

// Direct-form FIR for up to two audio channels sharing one coefficient set. A load request
// writes one coefficient. A sample request is written into its channel's history and then
// one multiply-accumulate runs for each of N taps against the coefficient and history
// memories, one read of each per cycle, where N is the smallest of taps_in_use, MAX_TAPS
// and the number of samples that channel has received. Only one request is in flight; a
// finished result waits in the output register while the next request is accepted. History
// beyond the per-channel fill count is never read, so there is no clearing pass after reset.
// Coefficients must be loaded before they are used. taps_in_use must be written only while
// the block is idle; the block itself does not enforce this.
module stereo_fir_filter_stateful #(
	parameter int MAX_TAPS     = sfir_pkg::MAX_TAPS_DEF,
	parameter int SAMPLE_BITS  = sfir_pkg::SAMPLE_BITS_DEF,
	parameter int NUM_CHANNELS = sfir_pkg::NUM_CHANNELS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [sfir_pkg::TAPS_W-1:0] cfg_wdata,
	sfir_in_if.sink                     req,
	sfir_out_if.source                  rsp
);
	import sfir_pkg::*;

	localparam int HIST_CH = (NUM_CHANNELS > 1) ? 2 : 1;
	localparam int PTR_W   = $clog2(MAX_TAPS);
	localparam int CNT_W   = $clog2(MAX_TAPS + 1);
	localparam int HA_W    = $clog2(HIST_CH * MAX_TAPS);
	localparam int CMP_W   = 12;
	localparam int FRAC    = SAMPLE_BITS - 1;
	localparam int ACC_FULL = 2 * SAMPLE_BITS + PTR_W + 1;
	localparam int ACC_W   = (ACC_FULL > 64) ? 64 : ACC_FULL;
	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC - 1);
	localparam logic [CMP_W-1:0] MAX_TAPS_C = CMP_W'(MAX_TAPS);

	logic [SAMPLE_BITS-1:0] coef_mem [MAX_TAPS];
	logic [SAMPLE_BITS-1:0] hist_mem [HIST_CH * MAX_TAPS];

	fir_state_t state_q, state_d;

	logic [TAPS_W-1:0] taps_q;
	logic [PTR_W-1:0]  ptr_q  [2];
	logic [CNT_W-1:0]  fill_q [2];

	logic             ch_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] k_q;
	logic [PTR_W-1:0] pos_q;

	logic                            valid_s1, valid_s2;
	logic signed [SAMPLE_BITS-1:0]   coef_s1, hist_s1;
	logic signed [2*SAMPLE_BITS-1:0] prod_s2;
	logic signed [ACC_W-1:0]         acc_q, rnd_q;

	logic                          out_valid_q;
	logic                          out_ch_q;
	logic signed [SAMPLE_BITS-1:0] out_data_q;

	logic accept, is_load, is_sample, ch_ok, issue, out_load, pipe_empty;
	logic [CMP_W-1:0]       tap_ext, taps_ext, fill_ext, fill_new_ext, eff_taps, n_ext;
	logic [HA_W-1:0]        hist_waddr, hist_raddr;
	logic [PTR_W-1:0]       ptr_cur;
	logic [SAMPLE_BITS-1:0] sat_value;

	assign accept    = req.valid && req.ready;
	assign is_load   = (req.req_type == REQ_LOAD);
	assign is_sample = (req.req_type == REQ_SAMPLE);
	assign ch_ok     = (HIST_CH > 1) || (req.channel == 1'b0);

	// Effective tap count: the register limited to MAX_TAPS and to the samples seen so far.
	always_comb begin
		tap_ext      = CMP_W'(req.tap_index);
		taps_ext     = CMP_W'(taps_q);
		fill_ext     = CMP_W'(fill_q[req.channel]);
		fill_new_ext = (fill_ext == MAX_TAPS_C) ? fill_ext : fill_ext + CMP_W'(1);
		eff_taps     = (taps_ext > MAX_TAPS_C) ? MAX_TAPS_C : taps_ext;
		n_ext        = (eff_taps > fill_new_ext) ? fill_new_ext : eff_taps;
		ptr_cur      = ptr_q[req.channel];
		hist_waddr   = (req.channel ? HA_W'(MAX_TAPS) : HA_W'(0)) + HA_W'(ptr_cur);
		hist_raddr   = (ch_q ? HA_W'(MAX_TAPS) : HA_W'(0)) + HA_W'(pos_q);
	end

	assign issue      = (state_q == ST_RUN) && (k_q < n_q);
	assign pipe_empty = !valid_s1 && !valid_s2;

	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && is_sample && ch_ok) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (k_q == n_q && pipe_empty) state_d = ST_ROUND;
			end
			ST_ROUND: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign req.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			taps_q      <= TAPS_W'(TAPS_RESET);
			ptr_q[0]    <= '0;
			ptr_q[1]    <= '0;
			fill_q[0]   <= '0;
			fill_q[1]   <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			k_q         <= '0;
			n_q         <= '0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
			if (cfg_we) taps_q <= cfg_wdata;
			if (accept && is_sample && ch_ok) begin
				ptr_q[req.channel]  <= (ptr_cur == PTR_W'(MAX_TAPS - 1)) ? '0
				                       : ptr_cur + PTR_W'(1);
				fill_q[req.channel] <= fill_new_ext[CNT_W-1:0];
				n_q                 <= n_ext[CNT_W-1:0];
				k_q                 <= '0;
			end else if (issue) begin
				k_q <= k_q + CNT_W'(1);
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	// Memories. The sample is written at acceptance, so the first tap read, in the cycle after
	// acceptance, already sees it.
	always_ff @(posedge clk) begin
		if (accept && is_load && (tap_ext < MAX_TAPS_C))
			coef_mem[tap_ext[PTR_W-1:0]] <= req.data_value;
		if (accept && is_sample && ch_ok)
			hist_mem[hist_waddr] <= req.data_value;
		coef_s1 <= coef_mem[k_q[PTR_W-1:0]];
		hist_s1 <= hist_mem[hist_raddr];
	end

	// Datapath: history walk, multiply, accumulate, round.
	always_ff @(posedge clk) begin
		if (accept && is_sample && ch_ok) begin
			ch_q  <= req.channel;
			pos_q <= ptr_cur;
		end else if (issue) begin
			pos_q <= (pos_q == '0) ? PTR_W'(MAX_TAPS - 1) : pos_q - PTR_W'(1);
		end
		prod_s2 <= coef_s1 * hist_s1;
		if (accept) acc_q <= '0;
		else if (valid_s2) acc_q <= acc_q + ACC_W'(prod_s2);
		if (state_q == ST_ROUND) rnd_q <= acc_q + ROUND_HALF;
		if (out_load) begin
			out_ch_q   <= ch_q;
			out_data_q <= sat_value;
		end
	end

	// The arithmetic shift of the rounded sum must fit the output width, else clamp.
	always_comb begin
		if (rnd_q[ACC_W-1]) begin
			if (&rnd_q[ACC_W-1:FRAC+SAMPLE_BITS-1]) sat_value = rnd_q[FRAC+SAMPLE_BITS-1:FRAC];
			else sat_value = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			if (|rnd_q[ACC_W-1:FRAC+SAMPLE_BITS-1]) sat_value = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
			else sat_value = rnd_q[FRAC+SAMPLE_BITS-1:FRAC];
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.out_channel     = out_ch_q;
	assign rsp.filtered_sample = out_data_q;

endmodule
